// ===== hw/rtl/abps_pkg.sv =====
// Shared types, codes and constants of the alpha blend pixel store.
`timescale 1ns / 1ps
`default_nettype none
package abps_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int IDX_W     = 24;  // covers 4096 x 4096 pixels
	localparam int QDEPTH    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;
	localparam logic [23:0]      WHITE_RGB = 24'hFFFFFF;
	localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
	localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [1:0] {
		ST_OPAQUE = 2'd0,
		ST_BLEND  = 2'd1,
		ST_SKIP   = 2'd2,
		ST_OOB    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_MIX,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic [7:0]         src_alpha;
		logic [7:0]         src_red;
		logic [7:0]         src_green;
		logic [7:0]         src_blue;
	} pix_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} res_t;

	// classified pixel write handed from front to back
	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] idx;
		logic [7:0]       alpha;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/alpha_blend_pixel_store.sv =====
// Top level of the alpha blend pixel store.
//
// Pixel writes enter on pix (valid/stall), each an x, y and ARGB color.
// Every accepted item gives exactly one item on res: a status
// (stored opaque, blended, skipped transparent, out of bounds) and the
// RGB now held at that position (zero when out of bounds).
// Image width and height are written through cfg_we/cfg_index/cfg_wdata;
// the user must do so only while the block is idle (the block itself does
// not enforce this). The store is addressed as x + y * width.
// Each item passes the pop, read, multiply and divide/write states of the
// back end's one-item-at-a-time sequencer before the next item is taken.
// A two-entry queue lets pix keep accepting while a result waits on res.
// After reset the store is cleared to white, one pixel per cycle, all
// MAX_WIDTH * MAX_HEIGHT pixels (65536 by default), with pix_stall high.
// While res_stall is high the result holds; the back end takes no new
// item until its result register is free, then the queue fills and
// pix_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module alpha_blend_pixel_store #(
	parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [abps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [abps_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           pix_valid,
	output logic                          pix_stall,
	input  abps_pkg::pix_t                pix,
	output logic                          res_valid,
	input  wire                           res_stall,
	output abps_pkg::res_t                res
);

	abps_pkg::job_t wr_job;
	abps_pkg::job_t rd_job;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	logic           busy;

	abps_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_stall (pix_stall),
		.busy      (busy),
		.full      (full),
		.push      (push),
		.job       (wr_job)
	);

	abps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	abps_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rd_job    (rd_job),
		.pop       (pop),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/abps_front.sv =====
// Front end: size registers, bounds check, alpha classification, store index.
`timescale 1ns / 1ps
`default_nettype none
module abps_front #(
	parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [abps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [abps_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire                                pix_valid,
	input  abps_pkg::pix_t                     pix,
	output logic                               pix_stall,
	input  wire                                busy,
	input  wire                                full,
	output logic                               push,
	output abps_pkg::job_t                     job
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = YW + WW;

	logic [abps_pkg::CFG_W-1:0] width_q;
	logic [abps_pkg::CFG_W-1:0] height_q;
	logic [15:0]                w_sat;
	logic [15:0]                h_sat;
	logic [15:0]                xu;
	logic [15:0]                yu;
	logic                       in_bounds;
	logic [PW-1:0]              prod;
	logic [PW-1:0]              lin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= abps_pkg::DIM_RESET;
			height_q <= abps_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abps_pkg::CFG_WIDTH:  width_q  <= cfg_wdata;
				abps_pkg::CFG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_sat = (16'(width_q) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(width_q);
		h_sat = (16'(height_q) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(height_q);
		xu = pix.x_pos;
		yu = pix.y_pos;
		in_bounds = !xu[15] && !yu[15] && (xu < w_sat) && (yu < h_sat);

		// x < w and y < h keep the index below MAX_WIDTH * MAX_HEIGHT
		prod = PW'(yu[YW-1:0]) * PW'(w_sat[WW-1:0]);
		lin  = prod + PW'(xu[XW-1:0]);

		job.idx   = in_bounds ? (abps_pkg::IDX_W)'(lin) : '0;
		job.alpha = pix.src_alpha;
		job.red   = pix.src_red;
		job.green = pix.src_green;
		job.blue  = pix.src_blue;
		if (!in_bounds)
			job.status = abps_pkg::ST_OOB;
		else if (pix.src_alpha == abps_pkg::ALPHA_CLEAR)
			job.status = abps_pkg::ST_SKIP;
		else if (pix.src_alpha == abps_pkg::ALPHA_OPAQUE)
			job.status = abps_pkg::ST_OPAQUE;
		else
			job.status = abps_pkg::ST_BLEND;

		pix_stall = busy || full;
		push      = pix_valid && !pix_stall;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/abps_queue.sv =====
// Short job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module abps_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  abps_pkg::job_t wr_job,
	output logic           full,
	input  wire            pop,
	output abps_pkg::job_t rd_job,
	output logic           empty
);

	localparam int PTR_W = (abps_pkg::QDEPTH > 1) ? $clog2(abps_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(abps_pkg::QDEPTH + 1);

	abps_pkg::job_t   ent_q [abps_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == CNT_W'(abps_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(abps_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(abps_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/abps_back.sv =====
// Back end: pixel memory with clearing pass, read-blend-write sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
module abps_back #(
	parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            empty,
	input  abps_pkg::job_t rd_job,
	output logic           pop,
	output logic           busy,
	output logic           res_valid,
	input  wire            res_stall,
	output abps_pkg::res_t res
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// exact x / 255 for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] s);
		logic [16:0] t;
		t = 17'(s) + 17'(s[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	abps_pkg::back_state_t state_q, state_d;

	logic [23:0]    mem [DEPTH];
	logic [AW-1:0]  clr_q;
	abps_pkg::job_t job_q;
	logic [23:0]    rd_q;
	logic [15:0]    sum_r_q, sum_g_q, sum_b_q;
	logic [7:0]     inv_a;
	logic           rd_en;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [23:0]    mem_wd;
	logic           load_res;
	logic [23:0]    new_rgb;
	logic           res_valid_q;
	abps_pkg::res_t res_q;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign busy      = (state_q == abps_pkg::BK_CLEAR);
	assign inv_a     = abps_pkg::ALPHA_OPAQUE - job_q.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= abps_pkg::BK_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		case (job_q.status)
			abps_pkg::ST_OPAQUE: new_rgb = {job_q.red, job_q.green, job_q.blue};
			abps_pkg::ST_BLEND:  new_rgb = {div255(sum_r_q), div255(sum_g_q), div255(sum_b_q)};
			abps_pkg::ST_SKIP:   new_rgb = rd_q;
			default:             new_rgb = '0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		load_res = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = clr_q;
		mem_wd   = abps_pkg::WHITE_RGB;
		unique case (state_q)
			abps_pkg::BK_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == AW'(DEPTH - 1))
					state_d = abps_pkg::BK_IDLE;
			end
			abps_pkg::BK_IDLE: begin
				if (!empty && (!res_valid_q || !res_stall)) begin
					pop     = 1'b1;
					state_d = abps_pkg::BK_READ;
				end
			end
			abps_pkg::BK_READ: begin
				rd_en   = 1'b1;
				state_d = abps_pkg::BK_MIX;
			end
			abps_pkg::BK_MIX: begin
				state_d = abps_pkg::BK_DONE;
			end
			abps_pkg::BK_DONE: begin
				load_res = 1'b1;
				mem_we   = (job_q.status == abps_pkg::ST_OPAQUE) ||
				           (job_q.status == abps_pkg::ST_BLEND);
				mem_wa   = job_q.idx[AW-1:0];
				mem_wd   = new_rgb;
				state_d  = abps_pkg::BK_IDLE;
			end
			default: state_d = abps_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (rd_en)
			rd_q <= mem[job_q.idx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= rd_job;
		if (state_q == abps_pkg::BK_MIX) begin
			sum_r_q <= 16'(rd_q[23:16]) * 16'(inv_a) + 16'(job_q.red) * 16'(job_q.alpha);
			sum_g_q <= 16'(rd_q[15:8]) * 16'(inv_a) + 16'(job_q.green) * 16'(job_q.alpha);
			sum_b_q <= 16'(rd_q[7:0]) * 16'(inv_a) + 16'(job_q.blue) * 16'(job_q.alpha);
		end
		if (load_res) begin
			res_q.status    <= job_q.status;
			res_q.out_red   <= new_rgb[23:16];
			res_q.out_green <= new_rgb[15:8];
			res_q.out_blue  <= new_rgb[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == abps_pkg::BK_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (load_res)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== tb/abps_checker.sv =====
// Checker for the alpha blend pixel store: mirrors the store and checks every result item.
`timescale 1ns / 1ps
module abps_checker #(
	parameter int MAX_W = abps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_H = abps_pkg::DEF_MAX_HEIGHT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [abps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [abps_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           pix_valid,
	input  wire                           pix_stall,
	input  abps_pkg::pix_t                pix,
	input  wire                           res_valid,
	input  wire                           res_stall,
	input  abps_pkg::res_t                res,
	input  wire                           end_check,
	output int                            errors,
	output int                            pending,
	output int                            n_opaque,
	output int                            n_blend,
	output int                            n_skip,
	output int                            n_oob
);
	import abps_pkg::*;

	logic [23:0]        pixel_mirror [0:MAX_W*MAX_H-1];
	logic [CFG_W-1:0]   img_w;
	logic [CFG_W-1:0]   img_h;
	res_t               want_q [$];
	int                 err_cnt;
	int                 cnt_opaque, cnt_blend, cnt_skip, cnt_oob;
	bit                 end_done;

	initial begin
		for (int i = 0; i < MAX_W * MAX_H; i++)
			pixel_mirror[i] = WHITE_RGB;
	end

	task automatic report(input string what, input int got, input int want_v);
		err_cnt++;
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want_v);
	endtask

	function automatic logic [7:0] mix_chan(input logic [7:0] old, input logic [7:0] src,
			input int a);
		int v;
		v = (int'(old) * (255 - a) + int'(src) * a) / 255;
		return v[7:0];
	endfunction

	// source-over write into the mirror; returns the result item it should produce
	function automatic res_t apply_write(input pix_t p);
		int          xs, ys, wd, ht, addr, a;
		logic [23:0] cur;
		res_t        r;
		xs = $signed(p.x_pos);
		ys = $signed(p.y_pos);
		wd = (int'(img_w) > MAX_W) ? MAX_W : int'(img_w);
		ht = (int'(img_h) > MAX_H) ? MAX_H : int'(img_h);
		r = '0;
		if (xs < 0 || ys < 0 || xs >= wd || ys >= ht) begin
			r.status = ST_OOB;
			return r;
		end
		addr = xs + ys * wd;
		cur = pixel_mirror[addr];
		a = int'(p.src_alpha);
		if (p.src_alpha == ALPHA_CLEAR) begin
			r.status = ST_SKIP;
		end else if (p.src_alpha == ALPHA_OPAQUE) begin
			cur = {p.src_red, p.src_green, p.src_blue};
			r.status = ST_OPAQUE;
		end else begin
			cur = {mix_chan(cur[23:16], p.src_red, a), mix_chan(cur[15:8], p.src_green, a),
				mix_chan(cur[7:0], p.src_blue, a)};
			r.status = ST_BLEND;
		end
		pixel_mirror[addr] = cur;
		{r.out_red, r.out_green, r.out_blue} = cur;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			img_w = DIM_RESET;
			img_h = DIM_RESET;
			want_q.delete();
			end_done = 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (want_q.size() == 0) begin
					report("unexpected result item", res.status, 0);
				end else begin
					want = want_q.pop_front();
					if (res.status !== want.status)
						report("status", res.status, want.status);
					if (res.out_red !== want.out_red)
						report("out_red", res.out_red, want.out_red);
					if (res.out_green !== want.out_green)
						report("out_green", res.out_green, want.out_green);
					if (res.out_blue !== want.out_blue)
						report("out_blue", res.out_blue, want.out_blue);
					case (want.status)
						ST_OPAQUE: cnt_opaque++;
						ST_BLEND:  cnt_blend++;
						ST_SKIP:   cnt_skip++;
						default:   cnt_oob++;
					endcase
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  img_w = cfg_wdata;
					CFG_HEIGHT: img_h = cfg_wdata;
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				want_q.push_back(apply_write(pix));
			if (end_check && !end_done) begin
				if (want_q.size() != 0)
					report("leftover expected items", want_q.size(), 0);
				end_done = 1'b1;
			end
		end
		errors   <= err_cnt;
		pending  <= want_q.size();
		n_opaque <= cnt_opaque;
		n_blend  <= cnt_blend;
		n_skip   <= cnt_skip;
		n_oob    <= cnt_oob;
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the alpha blend pixel store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import abps_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 pix_valid;
	logic                 pix_stall;
	pix_t                 pix;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 end_check;

	int errors, pending, n_opaque, n_blend, n_skip, n_oob;

	logic quiet   = 1'b0;  // no idling on either side
	logic hold_rx = 1'b0;  // ask the receiver for one long hold-off
	int   we_eff, he_eff;
	int   last_x, last_y;
	int   n_sent, n_geo;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	alpha_blend_pixel_store uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	abps_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.end_check (end_check),
		.errors    (errors),
		.pending   (pending),
		.n_opaque  (n_opaque),
		.n_blend   (n_blend),
		.n_skip    (n_skip),
		.n_oob     (n_oob)
	);

	initial begin
		#1_500_000;
		$display("[alpha_blend_pixel_store] ERROR");
		$finish;
	end

	// result side: random stall per item, plus one long hold-off on request
	initial begin : rx
		int gap;
		res_stall = 1'b0;
		forever begin
			if (hold_rx) begin
				gap = 150;
				hold_rx = 1'b0;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 16);
			end
			@(negedge clk);
			if (gap != 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	function automatic pix_t pixel_write(input int x, input int y, input int a, input int r,
			input int g, input int b);
		pix_t p;
		p.x_pos     = x[15:0];
		p.y_pos     = y[15:0];
		p.src_alpha = a[7:0];
		p.src_red   = r[7:0];
		p.src_green = g[7:0];
		p.src_blue  = b[7:0];
		return p;
	endfunction

	task automatic send_pix(input pix_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (!(pix_valid && !pix_stall));
		n_sent++;
	endtask

	// stop sending and wait until every expected item has come back
	task automatic drain;
		@(negedge clk);
		pix_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data[CFG_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_geometry(input int w, input int h);
		drain();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		we_eff = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		he_eff = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
		last_x = 0;
		last_y = 0;
		n_geo++;
	endtask

	// mostly in-bounds writes, many on the same or nearby pixel to stress repeated blends into one pixel
	function automatic pix_t rand_pix();
		pix_t        p;
		int          pick, x, y;
		logic [31:0] rnd;
		rnd = $urandom;
		{p.src_red, p.src_green, p.src_blue} = rnd[23:0];
		case ($urandom_range(0, 3))
			0:       p.src_alpha = ALPHA_CLEAR;
			1:       p.src_alpha = ALPHA_OPAQUE;
			default: p.src_alpha = rnd[31:24];
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 70 && we_eff > 0 && he_eff > 0) begin
			if (pick < 20) begin
				x = last_x;
				y = last_y;
			end else if (pick < 35) begin
				x = last_x + $urandom_range(0, 3);
				y = last_y + $urandom_range(0, 1);
				if (x >= we_eff) x = we_eff - 1;
				if (y >= he_eff) y = he_eff - 1;
			end else begin
				x = $urandom_range(0, we_eff - 1);
				y = $urandom_range(0, he_eff - 1);
			end
			last_x = x;
			last_y = y;
		end else if (pick < 85) begin
			x = $urandom_range(0, we_eff);
			y = $urandom_range(0, he_eff);
			case ($urandom_range(0, 3))
				0:       x = -1;
				1:       x = we_eff;
				2:       y = he_eff;
				default: y = -int'($urandom_range(1, 40));
			endcase
		end else begin
			rnd = $urandom;
			x = rnd[15:0];
			y = rnd[31:16];
		end
		p.x_pos = x[15:0];
		p.y_pos = y[15:0];
		return p;
	endfunction

	task automatic run_phase(input int w, input int h, input int n, input bit squeeze);
		set_geometry(w, h);
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (squeeze && i == 8) begin
				quiet   = 1'b1;
				hold_rx = 1'b1;
			end
			if (squeeze && i == 60)
				drain();
			send_pix(rand_pix());
		end
		quiet = 1'b0;
	endtask

	initial begin : stim
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_wdata = '0;
		pix_valid = 1'b0;
		pix       = '0;
		end_check = 1'b0;
		n_sent    = 0;
		n_geo     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_geometry(DIM_RESET, DIM_RESET);
		send_pix(pixel_write(0, 0, 255, 12, 34, 56));
		send_pix(pixel_write(0, 0, 0, 1, 2, 3));          // transparent: stored pixel kept
		send_pix(pixel_write(0, 0, 128, 255, 0, 128));
		send_pix(pixel_write(0, 0, 1, 0, 0, 0));
		send_pix(pixel_write(0, 0, 254, 255, 255, 255));
		send_pix(pixel_write(255, 255, 254, 0, 0, 0));    // blend over untouched white
		send_pix(pixel_write(255, 0, 0, 9, 9, 9));
		send_pix(pixel_write(0, 255, 255, 0, 0, 0));
		send_pix(pixel_write(-1, 0, 255, 1, 1, 1));
		send_pix(pixel_write(0, -1, 255, 1, 1, 1));
		send_pix(pixel_write(256, 0, 255, 1, 1, 1));
		send_pix(pixel_write(0, 256, 255, 1, 1, 1));
		send_pix(pixel_write(-32768, -32768, 0, 0, 0, 0));
		send_pix(pixel_write(32767, 32767, 255, 255, 255, 255));
		send_pix(pixel_write(128, 77, 255, 255, 0, 255));
		send_pix(pixel_write(128, 77, 100, 0, 255, 0));
		// zero width: everything out of bounds
		set_geometry(0, 256);
		send_pix(pixel_write(0, 0, 255, 7, 7, 7));
		send_pix(pixel_write(5, 5, 128, 7, 7, 7));
		// oversize registers saturate
		set_geometry(511, 511);
		send_pix(pixel_write(255, 255, 0, 0, 0, 0));
		send_pix(pixel_write(0, 255, 0, 0, 0, 0));
		// narrow geometry reads old contents through the new addressing
		set_geometry(10, 3);
		send_pix(pixel_write(8, 2, 0, 0, 0, 0));
		send_pix(pixel_write(9, 0, 60, 0, 0, 0));

		run_phase(256, 256, 90, 1'b1);
		run_phase(1, 1, 40, 1'b0);
		run_phase(16, 8, 80, 1'b0);
		run_phase(511, 511, 80, 1'b0);
		run_phase(255, 1, 60, 1'b0);
		run_phase(1, 255, 60, 1'b0);
		run_phase(0, 256, 25, 1'b0);
		run_phase(256, 0, 25, 1'b0);
		run_phase(37, 200, 80, 1'b0);
		run_phase(300, 12, 60, 1'b0);
		run_phase(100, 100, 80, 1'b0);
		run_phase(256, 256, 80, 1'b0);

		@(negedge clk);
		pix_valid <= 1'b0;
		for (int k = 0; k < 5000 && pending != 0; k++) @(posedge clk);
		repeat (12) @(posedge clk);
		@(negedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		$display("run covered %0d pixel writes across %0d geometries (zero, one-pixel, oversize)",
			n_sent, n_geo);
		$display("checked %0d opaque stores, %0d blends, %0d transparent skips, %0d out of bounds",
			n_opaque, n_blend, n_skip, n_oob);
		if (errors == 0)
			$display("[alpha_blend_pixel_store] OK");
		else
			$display("[alpha_blend_pixel_store] ERROR");
		$finish;
	end

endmodule
